// ===== rtl/core/cpt_pkg.sv =====
// Shared types, widths, region codes and helpers for the closest point on triangle pipeline.
// No dependencies; used by cpt_wdiv and closest_point_on_triangle.
package cpt_pkg;

    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int EDGE_BITS        = COORD_BITS + 1;
    localparam int DOT_BITS         = 2 * EDGE_BITS + 2;
    localparam int HALF_BITS        = DOT_BITS / 2;
    localparam int MUL_BITS         = 2 * DOT_BITS;
    localparam int DEN_BITS         = MUL_BITS + 2;
    localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
    localparam int PW_BITS          = WEIGHT_BITS + 1 + EDGE_BITS;
    localparam int SUM_BITS         = PW_BITS + 1;
    localparam int QRAW_BITS        = SUM_BITS + 1;
    localparam int SQ_BITS          = 2 * EDGE_BITS;
    localparam int DIST_BITS        = 34;
    localparam int DIV_STEPS        = WEIGHT_FRAC_BITS + 1;
    localparam int WDIV_LAT         = DIV_STEPS + 3;

    typedef logic signed [COORD_BITS-1:0]           coord_t;
    typedef logic signed [EDGE_BITS-1:0]            edge_t;
    typedef coord_t [2:0]                           vec3_t;
    typedef edge_t [2:0]                            evec3_t;
    typedef logic signed [2*EDGE_BITS-1:0]          prod_t;
    typedef logic signed [DOT_BITS-1:0]             dot_t;
    typedef logic signed [DOT_BITS+HALF_BITS-1:0]   pph_t;
    typedef logic signed [DOT_BITS+HALF_BITS:0]     ppl_t;
    typedef logic signed [MUL_BITS-1:0]             mul_t;
    typedef logic signed [MUL_BITS:0]               vdiff_t;
    typedef logic signed [DEN_BITS-1:0]             den_t;
    typedef logic [DEN_BITS:0]                      rem_t;
    typedef logic [DIV_STEPS-1:0]                   quo_t;
    typedef logic [WEIGHT_BITS-1:0]                 weight_t;
    typedef logic signed [PW_BITS-1:0]              wprod_t;
    typedef logic signed [SUM_BITS-1:0]             wsum_t;
    typedef logic signed [QRAW_BITS-1:0]            qraw_t;
    typedef logic [SQ_BITS-1:0]                     sq_t;
    typedef logic [DIST_BITS-1:0]                   dist_t;
    typedef logic [DIST_BITS:0]                     dsum_t;
    typedef logic [2:0]                             region_t;

    localparam region_t REGION_A  = 3'd0;
    localparam region_t REGION_B  = 3'd1;
    localparam region_t REGION_C  = 3'd2;
    localparam region_t REGION_AB = 3'd3;
    localparam region_t REGION_AC = 3'd4;
    localparam region_t REGION_BC = 3'd5;
    localparam region_t REGION_IN = 3'd6;

    localparam coord_t  COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t  COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam weight_t WEIGHT_ONE = weight_t'(1) << WEIGHT_FRAC_BITS;
    localparam wsum_t   WSUM_HALF  = wsum_t'(1) << (WEIGHT_FRAC_BITS - 1);

    typedef struct packed {
        vec3_t  query_point;
        vec3_t  vertex_a;
        vec3_t  vertex_b;
        vec3_t  vertex_c;
        evec3_t edge_ab;
        evec3_t edge_ac;
        evec3_t edge_bc;
    } cpt_in_t;

    typedef struct packed {
        vec3_t   nearest_point;
        dist_t   distance_squared;
        region_t region;
        logic    degenerate;
    } cpt_out_t;

    // Item data decided at the region stage and carried past the dividers.
    typedef struct packed {
        region_t region;
        logic    degen;
        vec3_t   p;
        vec3_t   base;
        evec3_t  e1;
        evec3_t  e2;
    } dec_t;

    function automatic coord_t sat_coord(input qraw_t x);
        coord_t r;
        if (x > qraw_t'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (x < qraw_t'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = coord_t'(x);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cpt_wdiv.sv =====
// Pipelined weight divider: num/den clamped to [0, 1], rounded to WEIGHT_FRAC_BITS.
// Depends on cpt_pkg; one division per cycle.
module cpt_wdiv (
    input  logic            clk,
    input  cpt_pkg::den_t   num,
    input  cpt_pkg::den_t   den,
    output cpt_pkg::weight_t weight
);

    cpt_pkg::den_t    norm_num_next, norm_den_next;
    cpt_pkg::den_t    norm_num_reg, norm_den_reg;
    logic             zero_next, one_next;
    cpt_pkg::rem_t    rem_reg  [cpt_pkg::DIV_STEPS+1];
    cpt_pkg::rem_t    dvs_reg  [cpt_pkg::DIV_STEPS+1];
    cpt_pkg::quo_t    quo_reg  [cpt_pkg::DIV_STEPS+1];
    logic             zero_reg [cpt_pkg::DIV_STEPS+1];
    logic             one_reg  [cpt_pkg::DIV_STEPS+1];
    logic [cpt_pkg::DIV_STEPS:0] quo_plus;
    cpt_pkg::weight_t weight_reg;

    // A negative divisor flips the signs of both operands.
    always_comb
    begin
        if (den[cpt_pkg::DEN_BITS-1]) begin
            norm_num_next = -num;
            norm_den_next = -den;
        end else begin
            norm_num_next = num;
            norm_den_next = den;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_num_reg <= norm_num_next;
        norm_den_reg <= norm_den_next;
    end

    always_comb
    begin
        zero_next = norm_num_reg[cpt_pkg::DEN_BITS-1] || (norm_num_reg == '0);
        one_next  = !zero_next && (norm_num_reg >= norm_den_reg);
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= {1'b0, norm_num_reg};
        dvs_reg[0]  <= {1'b0, norm_den_reg};
        quo_reg[0]  <= '0;
        zero_reg[0] <= zero_next;
        one_reg[0]  <= one_next;
    end

    // One restoring step per stage.
    genvar k;
    for (k = 0; k < cpt_pkg::DIV_STEPS; k++) begin : g_step
        cpt_pkg::rem_t shifted;
        logic          fits;

        assign shifted = {rem_reg[k][cpt_pkg::DEN_BITS-1:0], 1'b0};
        assign fits    = shifted >= dvs_reg[k];

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= fits ? shifted - dvs_reg[k] : shifted;
            dvs_reg[k+1]  <= dvs_reg[k];
            quo_reg[k+1]  <= {quo_reg[k][cpt_pkg::DIV_STEPS-2:0], fits};
            zero_reg[k+1] <= zero_reg[k];
            one_reg[k+1]  <= one_reg[k];
        end
    end

    assign quo_plus = {1'b0, quo_reg[cpt_pkg::DIV_STEPS]} + 1'b1;

    always_ff @(posedge clk)
    begin
        if (zero_reg[cpt_pkg::DIV_STEPS]) begin
            weight_reg <= '0;
        end else if (one_reg[cpt_pkg::DIV_STEPS]) begin
            weight_reg <= cpt_pkg::WEIGHT_ONE;
        end else begin
            weight_reg <= quo_plus[cpt_pkg::DIV_STEPS:1];
        end
    end

    assign weight = weight_reg;

endmodule

// ===== rtl/core/closest_point_on_triangle.sv =====
// Closest point on a 3D triangle: fully pipelined, one item accepted every clock cycle.
// The result of an item appears on result with done high once it has passed stages 1 to 7,
// the two weight dividers (20 stages each), point stages 1 to 3 and the output stage.
// busy is never asserted, and the receiver cannot stall, so throughput is one item per cycle.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on cpt_pkg and cpt_wdiv.
module closest_point_on_triangle (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cpt_pkg::cpt_in_t  query,
    output logic              done,
    output cpt_pkg::cpt_out_t result
);

    // Stage 1 holds the item and the vectors from each vertex to the query point.
    cpt_pkg::cpt_in_t s1_geom_reg;
    cpt_pkg::evec3_t  s1_ap_reg, s1_bp_reg, s1_cp_reg;
    logic             s1_v_reg;

    // Stage 2 holds the eighteen coordinate products of the six dot products.
    cpt_pkg::prod_t   s2_prod_next [6][3];
    cpt_pkg::prod_t   s2_prod_reg  [6][3];
    cpt_pkg::cpt_in_t s2_geom_reg;
    logic             s2_v_reg;

    // Stage 3 holds d1..d6 (index 0..5).
    cpt_pkg::dot_t    s3_d_reg [6];
    cpt_pkg::cpt_in_t s3_geom_reg;
    logic             s3_v_reg;

    // Stage 4 holds split partial products of the six wide products.
    cpt_pkg::dot_t    s4_mx [6];
    cpt_pkg::dot_t    s4_my [6];
    cpt_pkg::pph_t    s4_hi_reg [6];
    cpt_pkg::ppl_t    s4_lo_reg [6];
    cpt_pkg::dot_t    s4_d_reg [6];
    cpt_pkg::cpt_in_t s4_geom_reg;
    logic             s4_v_reg;

    // Stage 5 holds the full products; stage 6 the barycentric numerators va, vb, vc.
    cpt_pkg::mul_t    s5_m_reg [6];
    cpt_pkg::dot_t    s5_d_reg [6];
    cpt_pkg::cpt_in_t s5_geom_reg;
    logic             s5_v_reg;

    cpt_pkg::vdiff_t  s6_va_reg, s6_vb_reg, s6_vc_reg;
    cpt_pkg::dot_t    s6_d_reg [6];
    cpt_pkg::cpt_in_t s6_geom_reg;
    logic             s6_v_reg;

    // Stage 7 holds the region decision and the divider operands.
    cpt_pkg::dec_t    s7_dec_next, s7_dec_reg;
    cpt_pkg::den_t    s7_numv_next, s7_numw_next, s7_den_next;
    cpt_pkg::den_t    s7_numv_reg, s7_numw_reg, s7_den_reg;
    logic             s7_v_reg;

    // Item data travels beside the dividers.
    cpt_pkg::dec_t    side_reg   [cpt_pkg::WDIV_LAT];
    logic             side_v_reg [cpt_pkg::WDIV_LAT];
    cpt_pkg::weight_t weight_v, weight_w;
    cpt_pkg::dec_t    side_last;
    logic             side_v_last;

    // Point stages: weight products, rounded point, squared differences.
    cpt_pkg::wprod_t  p1_pv_reg [3];
    cpt_pkg::wprod_t  p1_pw_reg [3];
    cpt_pkg::dec_t    p1_dec_reg;
    logic             p1_v_reg;

    cpt_pkg::vec3_t   p2_q_next, p2_q_reg;
    cpt_pkg::dec_t    p2_dec_reg;
    logic             p2_v_reg;

    cpt_pkg::sq_t     p3_sq_next [3];
    cpt_pkg::sq_t     p3_sq_reg  [3];
    cpt_pkg::vec3_t   p3_q_reg;
    cpt_pkg::region_t p3_region_reg;
    logic             p3_degen_reg;
    logic             p3_v_reg;

    cpt_pkg::dsum_t   dsum;
    cpt_pkg::cpt_out_t result_reg;
    logic             done_reg;

    // The pipeline never holds off an item.
    assign busy = 1'b0;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            for (int i = 0; i < cpt_pkg::WDIV_LAT; i++) begin
                side_v_reg[i] <= 1'b0;
            end
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            s1_v_reg <= start && !busy;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            side_v_reg[0] <= s7_v_reg;
            for (int i = 1; i < cpt_pkg::WDIV_LAT; i++) begin
                side_v_reg[i] <= side_v_reg[i-1];
            end
            p1_v_reg <= side_v_last;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            done_reg <= p3_v_reg;
        end
    end

    // Stage 1: capture the item and form p-a, p-b, p-c.
    always_ff @(posedge clk)
    begin
        s1_geom_reg <= query;
        for (int i = 0; i < 3; i++) begin
            s1_ap_reg[i] <= cpt_pkg::edge_t'(query.query_point[i])
                          - cpt_pkg::edge_t'(query.vertex_a[i]);
            s1_bp_reg[i] <= cpt_pkg::edge_t'(query.query_point[i])
                          - cpt_pkg::edge_t'(query.vertex_b[i]);
            s1_cp_reg[i] <= cpt_pkg::edge_t'(query.query_point[i])
                          - cpt_pkg::edge_t'(query.vertex_c[i]);
        end
    end

    // Stage 2: products of ab and ac with each of the three offset vectors.
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            s2_prod_next[0][i] = cpt_pkg::prod_t'(s1_geom_reg.edge_ab[i])
                               * cpt_pkg::prod_t'(s1_ap_reg[i]);
            s2_prod_next[1][i] = cpt_pkg::prod_t'(s1_geom_reg.edge_ac[i])
                               * cpt_pkg::prod_t'(s1_ap_reg[i]);
            s2_prod_next[2][i] = cpt_pkg::prod_t'(s1_geom_reg.edge_ab[i])
                               * cpt_pkg::prod_t'(s1_bp_reg[i]);
            s2_prod_next[3][i] = cpt_pkg::prod_t'(s1_geom_reg.edge_ac[i])
                               * cpt_pkg::prod_t'(s1_bp_reg[i]);
            s2_prod_next[4][i] = cpt_pkg::prod_t'(s1_geom_reg.edge_ab[i])
                               * cpt_pkg::prod_t'(s1_cp_reg[i]);
            s2_prod_next[5][i] = cpt_pkg::prod_t'(s1_geom_reg.edge_ac[i])
                               * cpt_pkg::prod_t'(s1_cp_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_prod_reg <= s2_prod_next;
        s2_geom_reg <= s1_geom_reg;
    end

    // Stage 3: sum the coordinate products into the six dot products.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++) begin
            s3_d_reg[j] <= cpt_pkg::dot_t'(s2_prod_reg[j][0])
                         + cpt_pkg::dot_t'(s2_prod_reg[j][1])
                         + cpt_pkg::dot_t'(s2_prod_reg[j][2]);
        end
        s3_geom_reg <= s2_geom_reg;
    end

    // Stage 4: the products d1*d4, d3*d2, d5*d2, d1*d6, d3*d6 and d5*d4 are each split
    // into a signed upper half and an unsigned lower half of the second operand.
    always_comb
    begin
        s4_mx[0] = s3_d_reg[0]; s4_my[0] = s3_d_reg[3];
        s4_mx[1] = s3_d_reg[2]; s4_my[1] = s3_d_reg[1];
        s4_mx[2] = s3_d_reg[4]; s4_my[2] = s3_d_reg[1];
        s4_mx[3] = s3_d_reg[0]; s4_my[3] = s3_d_reg[5];
        s4_mx[4] = s3_d_reg[2]; s4_my[4] = s3_d_reg[5];
        s4_mx[5] = s3_d_reg[4]; s4_my[5] = s3_d_reg[3];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++) begin
            s4_hi_reg[k] <= cpt_pkg::pph_t'(s4_mx[k])
                * cpt_pkg::pph_t'($signed(s4_my[k][cpt_pkg::DOT_BITS-1:cpt_pkg::HALF_BITS]));
            s4_lo_reg[k] <= cpt_pkg::ppl_t'(s4_mx[k])
                * cpt_pkg::ppl_t'($signed({1'b0, s4_my[k][cpt_pkg::HALF_BITS-1:0]}));
        end
        s4_d_reg    <= s3_d_reg;
        s4_geom_reg <= s3_geom_reg;
    end

    // Stage 5: recombine the partial products.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++) begin
            s5_m_reg[k] <= (cpt_pkg::mul_t'(s4_hi_reg[k]) <<< cpt_pkg::HALF_BITS)
                         + cpt_pkg::mul_t'(s4_lo_reg[k]);
        end
        s5_d_reg    <= s4_d_reg;
        s5_geom_reg <= s4_geom_reg;
    end

    // Stage 6: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4.
    always_ff @(posedge clk)
    begin
        s6_vc_reg   <= cpt_pkg::vdiff_t'(s5_m_reg[0]) - cpt_pkg::vdiff_t'(s5_m_reg[1]);
        s6_vb_reg   <= cpt_pkg::vdiff_t'(s5_m_reg[2]) - cpt_pkg::vdiff_t'(s5_m_reg[3]);
        s6_va_reg   <= cpt_pkg::vdiff_t'(s5_m_reg[4]) - cpt_pkg::vdiff_t'(s5_m_reg[5]);
        s6_d_reg    <= s5_d_reg;
        s6_geom_reg <= s5_geom_reg;
    end

    // Stage 7: choose the Voronoi region. Corners feed the dividers 0/1 so that both
    // weights come out zero, which leaves the point on the corner itself. A zero divisor
    // falls back to vertex a the same way.
    always_comb
    begin
        logic corner;
        logic va_le, vb_le, vc_le;

        va_le = s6_va_reg[cpt_pkg::MUL_BITS] || (s6_va_reg == '0);
        vb_le = s6_vb_reg[cpt_pkg::MUL_BITS] || (s6_vb_reg == '0);
        vc_le = s6_vc_reg[cpt_pkg::MUL_BITS] || (s6_vc_reg == '0);

        corner              = 1'b1;
        s7_dec_next.region  = cpt_pkg::REGION_A;
        s7_dec_next.degen   = 1'b0;
        s7_dec_next.p       = s6_geom_reg.query_point;
        s7_dec_next.base    = s6_geom_reg.vertex_a;
        s7_dec_next.e1      = s6_geom_reg.edge_ab;
        s7_dec_next.e2      = s6_geom_reg.edge_ac;
        s7_numv_next        = '0;
        s7_numw_next        = '0;
        s7_den_next         = cpt_pkg::den_t'(1);

        if (s6_d_reg[0] <= cpt_pkg::dot_t'(0) && s6_d_reg[1] <= cpt_pkg::dot_t'(0)) begin
            s7_dec_next.region = cpt_pkg::REGION_A;
        end else if (s6_d_reg[2] >= cpt_pkg::dot_t'(0) && s6_d_reg[3] <= s6_d_reg[2]) begin
            s7_dec_next.region = cpt_pkg::REGION_B;
            s7_dec_next.base   = s6_geom_reg.vertex_b;
        end else if (s6_d_reg[5] >= cpt_pkg::dot_t'(0) && s6_d_reg[4] <= s6_d_reg[5]) begin
            s7_dec_next.region = cpt_pkg::REGION_C;
            s7_dec_next.base   = s6_geom_reg.vertex_c;
        end else if (vc_le && s6_d_reg[0] >= cpt_pkg::dot_t'(0)
                     && s6_d_reg[2] <= cpt_pkg::dot_t'(0)) begin
            corner             = 1'b0;
            s7_dec_next.region = cpt_pkg::REGION_AB;
            s7_numv_next       = cpt_pkg::den_t'(s6_d_reg[0]);
            s7_den_next        = cpt_pkg::den_t'(s6_d_reg[0]) - cpt_pkg::den_t'(s6_d_reg[2]);
        end else if (vb_le && s6_d_reg[1] >= cpt_pkg::dot_t'(0)
                     && s6_d_reg[5] <= cpt_pkg::dot_t'(0)) begin
            corner             = 1'b0;
            s7_dec_next.region = cpt_pkg::REGION_AC;
            s7_dec_next.e1     = s6_geom_reg.edge_ac;
            s7_numv_next       = cpt_pkg::den_t'(s6_d_reg[1]);
            s7_den_next        = cpt_pkg::den_t'(s6_d_reg[1]) - cpt_pkg::den_t'(s6_d_reg[5]);
        end else if (va_le && s6_d_reg[3] >= s6_d_reg[2] && s6_d_reg[4] >= s6_d_reg[5]) begin
            corner             = 1'b0;
            s7_dec_next.region = cpt_pkg::REGION_BC;
            s7_dec_next.base   = s6_geom_reg.vertex_b;
            s7_dec_next.e1     = s6_geom_reg.edge_bc;
            s7_numv_next       = cpt_pkg::den_t'(s6_d_reg[3]) - cpt_pkg::den_t'(s6_d_reg[2]);
            s7_den_next        = s7_numv_next
                               + cpt_pkg::den_t'(s6_d_reg[4]) - cpt_pkg::den_t'(s6_d_reg[5]);
        end else begin
            corner             = 1'b0;
            s7_dec_next.region = cpt_pkg::REGION_IN;
            s7_numv_next       = cpt_pkg::den_t'(s6_vb_reg);
            s7_numw_next       = cpt_pkg::den_t'(s6_vc_reg);
            s7_den_next        = cpt_pkg::den_t'(s6_va_reg) + cpt_pkg::den_t'(s6_vb_reg)
                               + cpt_pkg::den_t'(s6_vc_reg);
        end

        if (!corner && s7_den_next == '0) begin
            s7_dec_next.degen  = 1'b1;
            s7_dec_next.region = cpt_pkg::REGION_A;
            s7_dec_next.base   = s6_geom_reg.vertex_a;
            s7_numv_next       = '0;
            s7_numw_next       = '0;
            s7_den_next        = cpt_pkg::den_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        s7_dec_reg  <= s7_dec_next;
        s7_numv_reg <= s7_numv_next;
        s7_numw_reg <= s7_numw_next;
        s7_den_reg  <= s7_den_next;
    end

    // Weights along e1 (v) and e2 (w); the divisor is shared.
    cpt_wdiv u_wdiv_v (
        .clk    (clk),
        .num    (s7_numv_reg),
        .den    (s7_den_reg),
        .weight (weight_v)
    );

    cpt_wdiv u_wdiv_w (
        .clk    (clk),
        .num    (s7_numw_reg),
        .den    (s7_den_reg),
        .weight (weight_w)
    );

    always_ff @(posedge clk)
    begin
        side_reg[0] <= s7_dec_reg;
        for (int i = 1; i < cpt_pkg::WDIV_LAT; i++) begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_last   = side_reg[cpt_pkg::WDIV_LAT-1];
    assign side_v_last = side_v_reg[cpt_pkg::WDIV_LAT-1];

    // Point stage 1: weight times edge for each coordinate.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            p1_pv_reg[i] <= cpt_pkg::wprod_t'($signed({1'b0, weight_v}))
                          * cpt_pkg::wprod_t'(side_last.e1[i]);
            p1_pw_reg[i] <= cpt_pkg::wprod_t'($signed({1'b0, weight_w}))
                          * cpt_pkg::wprod_t'(side_last.e2[i]);
        end
        p1_dec_reg <= side_last;
    end

    // Point stage 2: round to the coordinate grid (floor after adding one half), add the
    // base vertex and saturate.
    always_comb
    begin
        cpt_pkg::wsum_t acc;
        for (int i = 0; i < 3; i++) begin
            acc = cpt_pkg::wsum_t'(p1_pv_reg[i]) + cpt_pkg::wsum_t'(p1_pw_reg[i])
                + cpt_pkg::WSUM_HALF;
            acc = acc >>> cpt_pkg::WEIGHT_FRAC_BITS;
            p2_q_next[i] = cpt_pkg::sat_coord(cpt_pkg::qraw_t'(acc)
                                            + cpt_pkg::qraw_t'(p1_dec_reg.base[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        p2_q_reg   <= p2_q_next;
        p2_dec_reg <= p1_dec_reg;
    end

    // Point stage 3: squared coordinate differences.
    always_comb
    begin
        cpt_pkg::edge_t diff;
        cpt_pkg::prod_t sq;
        for (int i = 0; i < 3; i++) begin
            diff = cpt_pkg::edge_t'(p2_dec_reg.p[i]) - cpt_pkg::edge_t'(p2_q_reg[i]);
            sq   = cpt_pkg::prod_t'(diff) * cpt_pkg::prod_t'(diff);
            p3_sq_next[i] = cpt_pkg::sq_t'(sq);
        end
    end

    always_ff @(posedge clk)
    begin
        p3_sq_reg     <= p3_sq_next;
        p3_q_reg      <= p2_q_reg;
        p3_region_reg <= p2_dec_reg.region;
        p3_degen_reg  <= p2_dec_reg.degen;
    end

    // Output stage: sum of squares, saturated to the field width.
    assign dsum = cpt_pkg::dsum_t'(p3_sq_reg[0]) + cpt_pkg::dsum_t'(p3_sq_reg[1])
                + cpt_pkg::dsum_t'(p3_sq_reg[2]);

    always_ff @(posedge clk)
    begin
        result_reg.nearest_point    <= p3_q_reg;
        result_reg.distance_squared <= dsum[cpt_pkg::DIST_BITS] ? '1
                                     : dsum[cpt_pkg::DIST_BITS-1:0];
        result_reg.region           <= p3_region_reg;
        result_reg.degenerate       <= p3_degen_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A corner (or a degenerate fallback) must leave both dividers at zero weight.
    a_corner_zero_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (side_v_last && (side_last.region == cpt_pkg::REGION_A
                         || side_last.region == cpt_pkg::REGION_B
                         || side_last.region == cpt_pkg::REGION_C))
        |-> (weight_v == '0 && weight_w == '0))
        else $error("corner region with nonzero weight");

    // On an edge only the first weight may be nonzero.
    a_edge_no_w: assert property (@(posedge clk) disable iff (!rst_n)
        (side_v_last && (side_last.region == cpt_pkg::REGION_AB
                         || side_last.region == cpt_pkg::REGION_AC
                         || side_last.region == cpt_pkg::REGION_BC))
        |-> (weight_w == '0))
        else $error("edge region with nonzero second weight");

    // A degenerate result always reports vertex a.
    a_degen_region: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |-> (result.region == cpt_pkg::REGION_A))
        else $error("degenerate result outside region a");

endmodule
